/* hdl/lum_pkg.sv */
// ----------------------------------------------------------------------------
// lum_pkg
// Shared widths, codes and types for the level utilization monitor.
// ----------------------------------------------------------------------------
package lum_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int MAX_LEVELS_DEF = 256;

  localparam int KIND_W     = 2;
  localparam int NEWLVL_W   = 8;
  localparam int LC_W       = 9;
  localparam int WIN_W      = 32;
  localparam int ACT_W      = 40;
  localparam int DEN_W      = 40;
  localparam int PE_W       = 48;
  localparam int PCT_W      = 15;
  localparam int ALU_W      = 56;
  localparam int CNT_W      = 4;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_INC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_COUNT   = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH = 8'd1;

  localparam logic [LC_W-1:0]  LC_RESET = 9'd2;
  localparam logic [WIN_W-1:0] WL_RESET = 32'd1000;

  // 25600 = 2^14 + 2^13 + 2^10
  localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;
  localparam int SCALE_SH0 = 10;
  localparam int SCALE_SH1 = 13;
  localparam int SCALE_SH2 = 14;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } lum_alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] y;
    logic             borrow;
  } lum_alu_rsp_t;

endpackage

/* hdl/lum_alu.sv */
// ----------------------------------------------------------------------------
// lum_alu
// Shared add/subtract unit used by the report sequencer.
// ----------------------------------------------------------------------------
module lum_alu (
  input  lum_pkg::lum_alu_req_t req_i,
  output lum_pkg::lum_alu_rsp_t rsp_o
);

  logic [lum_pkg::ALU_W:0] full;

  always_comb begin
    if (req_i.sub) begin
      full = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      full = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.y      = full[lum_pkg::ALU_W-1:0];
    rsp_o.borrow = req_i.sub & full[lum_pkg::ALU_W];
  end

endmodule

/* hdl/lum_seq.sv */
// ----------------------------------------------------------------------------
// lum_seq
// Report sequencer: shift-add denominator, scaled numerator, restoring
// division with saturation, and the result output register.
// ----------------------------------------------------------------------------
module lum_seq #(
  parameter int LVL_W = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [LVL_W-1:0]                  top_i,
  input  logic [lum_pkg::WIN_W-1:0]         wl_i,
  input  logic [lum_pkg::ACT_W-1:0]         act_i,
  input  logic [lum_pkg::PE_W-1:0]          pe_i,
  output logic                              busy_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [47:0] window end tick, [62:48] percent_scaled, [63] zero
  output logic [lum_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_NUM1 = 3'd2;
  localparam logic [2:0] ST_NUM2 = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                       state_q, state_d;
  logic [LVL_W-1:0]                 top_q, top_d;
  logic [lum_pkg::DEN_W-1:0]        wlsh_q, wlsh_d;
  logic [lum_pkg::DEN_W-1:0]        den_q, den_d;
  logic [lum_pkg::ACT_W-1:0]        act_q, act_d;
  logic [lum_pkg::ALU_W-1:0]        num_q, num_d;
  logic [lum_pkg::ALU_W-1:0]        dsh_q, dsh_d;
  logic [lum_pkg::PCT_W-1:0]        quo_q, quo_d;
  logic [lum_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [lum_pkg::PE_W-1:0]         pe_q, pe_d;
  logic                             ovalid_q, ovalid_d;
  logic [lum_pkg::OUT_DATA_W-1:0]   odata_q, odata_d;
  logic [lum_pkg::PCT_W-1:0]        pct;
  lum_pkg::lum_alu_req_t            alu_req;
  lum_pkg::lum_alu_rsp_t            alu_rsp;

  lum_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state_q)
      ST_MUL: begin
        alu_req.a = lum_pkg::ALU_W'(den_q);
        alu_req.b = lum_pkg::ALU_W'(wlsh_q);
      end
      ST_NUM1: begin
        alu_req.a = num_q;
        alu_req.b = lum_pkg::ALU_W'(act_q) << lum_pkg::SCALE_SH1;
      end
      ST_NUM2: begin
        alu_req.a = num_q;
        alu_req.b = lum_pkg::ALU_W'(act_q) << lum_pkg::SCALE_SH2;
      end
      ST_CHK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = num_q;
        alu_req.b   = lum_pkg::ALU_W'(den_q) << lum_pkg::PCT_W;
      end
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = num_q;
        alu_req.b   = dsh_q;
      end
      default: begin
      end
    endcase
  end

  assign pct = (quo_q > lum_pkg::PCT_MAX) ? lum_pkg::PCT_MAX : quo_q;

  always_comb begin
    state_d  = state_q;
    top_d    = top_q;
    wlsh_d   = wlsh_q;
    den_d    = den_q;
    act_d    = act_q;
    num_d    = num_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    pe_d     = pe_q;
    odata_d  = odata_q;
    ovalid_d = ovalid_q & ~m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          top_d   = top_i;
          wlsh_d  = lum_pkg::DEN_W'(wl_i);
          den_d   = '0;
          act_d   = act_i;
          num_d   = lum_pkg::ALU_W'(act_i) << lum_pkg::SCALE_SH0;
          pe_d    = pe_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (top_q == '0) begin
          state_d = ST_NUM1;
        end else begin
          if (top_q[0]) begin
            den_d = alu_rsp.y[lum_pkg::DEN_W-1:0];
          end
          top_d  = top_q >> 1;
          wlsh_d = wlsh_q << 1;
        end
      end
      ST_NUM1: begin
        num_d   = alu_rsp.y;
        state_d = ST_NUM2;
      end
      ST_NUM2: begin
        num_d   = alu_rsp.y;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (den_q == '0) begin
          quo_d   = '0;
          state_d = ST_DONE;
        end else if (!alu_rsp.borrow) begin
          quo_d   = lum_pkg::PCT_MAX;
          state_d = ST_DONE;
        end else begin
          quo_d   = '0;
          dsh_d   = lum_pkg::ALU_W'(den_q) << (lum_pkg::PCT_W - 1);
          cnt_d   = lum_pkg::CNT_W'(lum_pkg::PCT_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!alu_rsp.borrow) begin
          num_d = alu_rsp.y;
        end
        quo_d = {quo_q[lum_pkg::PCT_W-2:0], ~alu_rsp.borrow};
        dsh_d = dsh_q >> 1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          odata_d  = {1'b0, pct, pe_q};
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    wlsh_q  <= wlsh_d;
    den_q   <= den_d;
    act_q   <= act_d;
    num_q   <= num_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    pe_q    <= pe_d;
    odata_q <= odata_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

/* hdl/level_utilization_monitor.sv */
// ----------------------------------------------------------------------------
// level_utilization_monitor
// Usage level tracker with windowed utilization reports.
// ----------------------------------------------------------------------------
// Increase, decrease, set and non-closing tick requests are taken one per
// cycle while no report is in progress. A tick that closes a window starts a
// report: the sequencer runs one shared 56-bit add/subtract unit to form
// top * window_length by shift-add over the significant bits of the top level,
// scale the activity by 25600, check for saturation and run a 15-step
// restoring division unless the denominator is zero or the result saturates,
// then loads the output register. The input is not ready while the sequencer
// is busy; a finished report may wait on the output while new requests are
// taken.
module level_utilization_monitor #(
  parameter int TIME_BITS  = lum_pkg::TIME_BITS_DEF,
  parameter int MAX_LEVELS = lum_pkg::MAX_LEVELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] new_level
  input  logic [lum_pkg::NEWLVL_W-1:0]      s_axis_tdata,
  // [1:0] kind
  input  logic [lum_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [47:0] window end tick, [62:48] percent_scaled, [63] zero
  output logic [lum_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lum_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [lum_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LVL_W = $clog2(MAX_LEVELS);
  localparam logic [lum_pkg::LC_W-1:0] TOP_MAX = lum_pkg::LC_W'(MAX_LEVELS - 1);

  logic [lum_pkg::LC_W-1:0]    lc_q;
  logic [lum_pkg::WIN_W-1:0]   wl_q;
  logic [LVL_W-1:0]            lvl_q, lvl_d;
  logic [TIME_BITS-1:0]        elapsed_q, elapsed_d;
  logic [lum_pkg::WIN_W-1:0]   wt_q, wt_d, wt_inc;
  logic [lum_pkg::ACT_W-1:0]   act_q, act_d, act_inc;
  logic [lum_pkg::LC_W-1:0]    top9_raw, top9;
  logic [LVL_W-1:0]            top_lvl;
  logic [lum_pkg::WIN_W-1:0]   wl_eff;
  logic [TIME_BITS-1:0]        elapsed_inc;
  logic [lum_pkg::PE_W-1:0]    pe;
  logic                        in_acc, is_tick, close, busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= lum_pkg::LC_RESET;
      wl_q <= lum_pkg::WL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == lum_pkg::CFG_LEVEL_COUNT) begin
        lc_q <= cfg_data_i[lum_pkg::LC_W-1:0];
      end else if (cfg_addr_i == lum_pkg::CFG_WINDOW_LENGTH) begin
        wl_q <= cfg_data_i;
      end
    end
  end

  assign top9_raw = (lc_q == '0) ? '0 : lc_q - 1'b1;
  assign top9     = (top9_raw > TOP_MAX) ? TOP_MAX : top9_raw;
  assign top_lvl  = top9[LVL_W-1:0];
  assign wl_eff   = (wl_q == '0) ? lum_pkg::WIN_W'(1) : wl_q;

  assign in_acc      = s_axis_tvalid & s_axis_tready;
  assign is_tick     = (s_axis_tuser == lum_pkg::KIND_TICK);
  assign act_inc     = act_q + lum_pkg::ACT_W'(lvl_q);
  assign wt_inc      = wt_q + 1'b1;
  assign elapsed_inc = elapsed_q + 1'b1;
  assign close       = in_acc & is_tick & (wt_inc >= wl_eff);

  generate
    if (TIME_BITS >= lum_pkg::PE_W) begin : g_pe_trunc
      assign pe = elapsed_inc[lum_pkg::PE_W-1:0];
    end else begin : g_pe_ext
      assign pe = {{(lum_pkg::PE_W - TIME_BITS){1'b0}}, elapsed_inc};
    end
  endgenerate

  always_comb begin
    lvl_d     = lvl_q;
    elapsed_d = elapsed_q;
    wt_d      = wt_q;
    act_d     = act_q;
    if (in_acc) begin
      case (s_axis_tuser)
        lum_pkg::KIND_INC: begin
          if (lvl_q < top_lvl) begin
            lvl_d = lvl_q + 1'b1;
          end
        end
        lum_pkg::KIND_DEC: begin
          if (lvl_q != '0) begin
            lvl_d = lvl_q - 1'b1;
          end
        end
        lum_pkg::KIND_SET: begin
          if ({1'b0, s_axis_tdata} > top9) begin
            lvl_d = top_lvl;
          end else begin
            lvl_d = s_axis_tdata[LVL_W-1:0];
          end
        end
        default: begin
          elapsed_d = elapsed_inc;
          if (close) begin
            wt_d  = '0;
            act_d = '0;
          end else begin
            wt_d  = wt_inc;
            act_d = act_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      elapsed_q <= '0;
      wt_q      <= '0;
      act_q     <= '0;
    end else begin
      lvl_q     <= lvl_d;
      elapsed_q <= elapsed_d;
      wt_q      <= wt_d;
      act_q     <= act_d;
    end
  end

  lum_seq #(
    .LVL_W (LVL_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (close),
    .top_i           (top_lvl),
    .wl_i            (wl_eff),
    .act_i           (act_inc),
    .pe_i            (pe),
    .busy_o          (busy),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  assign s_axis_tready = ~busy;

  // a closing tick starts a report and blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> (!s_axis_tready && wt_q == '0 && act_q == '0))
    else $error("closing tick did not start a report");

  // reported percentage never passes full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[62:48] <= lum_pkg::PCT_MAX))
    else $error("percent above full scale");

  // a report only appears after a sequencer run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy))
    else $error("report without a sequencer run");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Level utilization monitor testbench
// Feeds increase, decrease, set and tick requests to the monitor under several
// level count and window length settings. It also changes the registers partway
// through a window. Both the sender and the receiver idle at random. A local
// model of the level, the tick counters and the utilization division predicts
// every window report, and each report that arrives is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int SHOWN_ERRORS  = 10;

  typedef struct {
    logic [lum_pkg::KIND_W-1:0]   kind;
    logic [lum_pkg::NEWLVL_W-1:0] level;
  } level_req_t;

  typedef struct {
    logic [lum_pkg::PE_W-1:0]  end_tick;
    logic [lum_pkg::PCT_W-1:0] percent;
  } window_report_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [lum_pkg::NEWLVL_W-1:0]   s_axis_tdata  = '0;
  logic [lum_pkg::KIND_W-1:0]     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [lum_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [lum_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [lum_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  level_req_t     pending_reqs[$];
  window_report_t expected_reports[$];

  // model of the block
  logic [lum_pkg::LC_W-1:0]     levels_cfg  = lum_pkg::LC_RESET;
  logic [lum_pkg::WIN_W-1:0]    window_cfg  = lum_pkg::WL_RESET;
  logic [lum_pkg::NEWLVL_W-1:0] cur_level   = '0;
  logic [lum_pkg::PE_W-1:0]     ticks_total = '0;
  logic [lum_pkg::WIN_W-1:0]    win_count   = '0;
  logic [lum_pkg::ACT_W-1:0]    win_sum     = '0;

  int errors       = 0;
  int send_gap     = 0;
  int send_calm    = 0;
  int recv_stall   = 0;
  int recv_calm    = 0;
  int quiet_cycles = 0;

  level_req_t     next_req;
  window_report_t want;

  level_utilization_monitor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("%s", msg);
  endtask

  task automatic apply_request(input logic [lum_pkg::KIND_W-1:0] kind,
                               input logic [lum_pkg::NEWLVL_W-1:0] req_level);
    logic [63:0] top;
    logic [63:0] span;
    logic [63:0] den;
    logic [63:0] scaled;
    logic [63:0] pct;
    window_report_t rep;
    top = (levels_cfg == 0) ? 64'd0 : 64'(levels_cfg) - 64'd1;
    if (top > 64'(lum_pkg::MAX_LEVELS_DEF - 1)) top = 64'(lum_pkg::MAX_LEVELS_DEF - 1);
    case (kind)
      lum_pkg::KIND_INC: if (64'(cur_level) < top) cur_level = cur_level + 1'b1;
      lum_pkg::KIND_DEC: if (cur_level != 0) cur_level = cur_level - 1'b1;
      lum_pkg::KIND_SET:
        cur_level = (64'(req_level) > top) ? top[lum_pkg::NEWLVL_W-1:0] : req_level;
      lum_pkg::KIND_TICK: begin
        win_sum     = win_sum + lum_pkg::ACT_W'(cur_level);
        ticks_total = ticks_total + 1'b1;
        win_count   = win_count + 1'b1;
        span = (window_cfg == 0) ? 64'd1 : 64'(window_cfg);
        if (64'(win_count) >= span) begin
          den    = top * span;
          scaled = 64'(win_sum) * 64'(lum_pkg::PCT_MAX);
          pct    = (den == 0) ? 64'd0 : scaled / den;
          if (pct > 64'(lum_pkg::PCT_MAX)) pct = 64'(lum_pkg::PCT_MAX);
          rep.end_tick = ticks_total;
          rep.percent  = pct[lum_pkg::PCT_W-1:0];
          expected_reports.insert(expected_reports.size(), rep);
          win_count = '0;
          win_sum   = '0;
        end
      end
    endcase
  endtask

  task automatic push_req(input logic [lum_pkg::KIND_W-1:0] kind,
                          input logic [lum_pkg::NEWLVL_W-1:0] level);
    level_req_t req;
    req.kind  = kind;
    req.level = level;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // called at a rising edge; leaves cfg_valid_i high for the caller to drop
  task automatic cfg_write(input logic [lum_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [lum_pkg::CFG_DATA_W-1:0] data);
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == lum_pkg::CFG_LEVEL_COUNT) levels_cfg = data[lum_pkg::LC_W-1:0];
    else window_cfg = data;
  endtask

  task automatic set_config(input logic [lum_pkg::LC_W-1:0] levels,
                            input logic [lum_pkg::WIN_W-1:0] win);
    cfg_write(lum_pkg::CFG_LEVEL_COUNT, lum_pkg::CFG_DATA_W'(levels));
    cfg_write(lum_pkg::CFG_WINDOW_LENGTH, win);
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until all requests are taken and all reports are back
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          s_axis_tuser  <= next_req.kind;
          s_axis_tdata  <= next_req.level;
          s_axis_tvalid <= 1'b1;
          send_gap = idle_len(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          log_error($sformatf("report %h arrived with none pending", m_axis_tdata));
        end else begin
          want = expected_reports.pop_front();
          if (m_axis_tdata[lum_pkg::PE_W-1:0] !== want.end_tick)
            log_error($sformatf("end tick: expected %0d, got %0d",
                                want.end_tick, m_axis_tdata[lum_pkg::PE_W-1:0]));
          if (m_axis_tdata[lum_pkg::PE_W+lum_pkg::PCT_W-1:lum_pkg::PE_W] !== want.percent)
            log_error($sformatf("percent_scaled at tick %0d: expected %0d, got %0d",
                                want.end_tick, want.percent,
                                m_axis_tdata[lum_pkg::PE_W+lum_pkg::PCT_W-1:lum_pkg::PE_W]));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall = idle_len(recv_calm);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int i;
    int r;
    int burst;
    logic [lum_pkg::KIND_W-1:0]   k;
    logic [lum_pkg::NEWLVL_W-1:0] lv;
    logic [lum_pkg::LC_W-1:0]     lc;
    logic [lum_pkg::WIN_W-1:0]    wl;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, level pinned at both limits
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_DEC, 8'd0);
    push_req(lum_pkg::KIND_DEC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_SET, 8'hFF);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();

    // shorter window than the ticks already gathered: next tick closes it
    set_config(9'd4, 32'd3);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_SET, 8'd0);
    push_req(lum_pkg::KIND_DEC, 8'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_SET, 8'd2);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();

    // level counts of zero and one: top level zero, zero window acts as one
    set_config(9'd0, 32'd1);
    push_req(lum_pkg::KIND_SET, 8'hFF);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();
    set_config(9'd1, 32'd0);
    push_req(lum_pkg::KIND_INC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();

    // level count above the maximum
    set_config(9'h1FF, 32'd0);
    push_req(lum_pkg::KIND_SET, 8'hFF);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_DEC, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();

    // shrink the level count under a high level, longest window, then saturate
    set_config(9'd2, 32'hFFFF_FFFF);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();
    set_config(9'd2, 32'd2);
    push_req(lum_pkg::KIND_TICK, 8'd0);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: lc = 9'd256;
        1: lc = 9'd2;
        2: lc = lum_pkg::LC_W'($urandom_range(2, 256));
        3: lc = lum_pkg::LC_W'($urandom_range(0, 511));
        default: lc = lum_pkg::LC_W'($urandom_range(2, 16));
      endcase
      r = $urandom_range(0, 9);
      if (r < 6) wl = $urandom_range(1, 20);
      else if (r < 9) wl = $urandom_range(21, 100);
      else wl = $urandom_range(0, 1);
      set_config(lc, wl);

      n = $urandom_range(120, 180);
      i = 0;
      while (i < n) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          burst = $urandom_range(2, 12);
          repeat (burst)
            push_req(lum_pkg::KIND_TICK, lum_pkg::NEWLVL_W'($urandom_range(0, 255)));
          i += burst;
        end else begin
          if (r < 50) k = lum_pkg::KIND_TICK;
          else if (r < 70) k = lum_pkg::KIND_INC;
          else if (r < 85) k = lum_pkg::KIND_DEC;
          else k = lum_pkg::KIND_SET;
          r = $urandom_range(0, 9);
          if (r == 0) lv = 8'hFF;
          else if (r == 1) lv = 8'h00;
          else lv = lum_pkg::NEWLVL_W'($urandom_range(0, 255));
          push_req(k, lv);
          i++;
        end
      end
      drain();
    end

    if (errors == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lum_pkg.sv
hdl/lum_alu.sv
hdl/lum_seq.sv
hdl/level_utilization_monitor.sv
dv/testbench.sv
